@@ rtl/core/msw_pkg.sv @@
// Package: cell codes, config indexes, hash constants and front-to-back record type.
package msw_pkg;

  typedef enum logic [1:0] {
    CELL_EMPTY = 2'd0,
    CELL_WATER = 2'd1,
    CELL_SAND  = 2'd2,
    CELL_WALL  = 2'd3
  } cell_e;

  localparam int unsigned NumRegs = 5;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SAND_NOISE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FALL_DOWN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DENSITY    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIAGONAL   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HORIZONTAL = 3'd4;

  localparam logic [31:0] HashKx = 32'd374761393;
  localparam logic [31:0] HashKy = 32'd668265263;
  localparam logic [31:0] HashKf = 32'd1274126177;
  localparam logic [31:0] HashKs = 32'd387413;

  // Hash decisions per salt, in salt order.
  typedef struct packed {
    logic horiz_bot;  // salt 5
    logic horiz_top;  // salt 4
    logic diag;       // salt 3
    logic dens;       // salt 2
    logic fall;       // salt 1
    logic noise;      // salt 0
  } chance_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [1:0] tl;
    logic [1:0] tr;
    logic [1:0] bl;
    logic [1:0] br;
    logic       floor_solid;
    chance_t    ch;
  } work_t;

endpackage

@@ rtl/core/msw_front.sv @@
// Front: pipelined hash of six salts, floor masking and chance decisions.
module msw_front #(
  parameter int unsigned GRID_WIDTH  = 1024,
  parameter int unsigned GRID_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         block_x_i,
  input  logic [9:0]         block_y_i,
  input  logic [31:0]        frame_i,
  input  logic [1:0]         top_left_i,
  input  logic [1:0]         top_right_i,
  input  logic [1:0]         bottom_left_i,
  input  logic [1:0]         bottom_right_i,
  input  logic [1:0]         floor_left_i,
  input  logic [1:0]         floor_right_i,
  input  logic [msw_pkg::NumRegs*msw_pkg::ThrW-1:0] thr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msw_pkg::work_t     out_o
);

  localparam int unsigned NSalt = 6;

  // Stage 1: products of coordinates and frame.
  logic        s1_valid_q, s2_valid_q, s3_valid_q;
  logic [31:0] px_q, py_q, pf_q;
  logic [7:0]  cells_q, cells2_q, cells3_q;
  logic        fsol_q, fsol2_q, fsol3_q;
  logic [31:0] n_q [NSalt];
  logic [15:0] h_q [NSalt];
  logic        advance;

  assign advance    = !s3_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Floor masking at grid edges.
  logic [1:0] fl, fr;
  always_comb begin
    fl = floor_left_i;
    fr = floor_right_i;
    if ({22'd0, block_y_i} + 32'd2 >= 32'(GRID_HEIGHT)) begin
      fl = msw_pkg::CELL_WALL;
      fr = msw_pkg::CELL_WALL;
    end
    if ({22'd0, block_x_i} + 32'd1 >= 32'(GRID_WIDTH)) fr = msw_pkg::CELL_WALL;
    if ({22'd0, block_x_i} >= 32'(GRID_WIDTH)) fl = msw_pkg::CELL_WALL;
  end

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Advance payload through the hash stages.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      px_q     <= {22'd0, block_x_i} * msw_pkg::HashKx;
      py_q     <= {22'd0, block_y_i} * msw_pkg::HashKy;
      pf_q     <= frame_i * msw_pkg::HashKf;
      cells_q  <= {top_left_i, top_right_i, bottom_left_i, bottom_right_i};
      fsol_q   <= (fl >= msw_pkg::CELL_WATER) && (fr >= msw_pkg::CELL_WATER);
      cells2_q <= cells_q;
      fsol2_q  <= fsol_q;
      cells3_q <= cells2_q;
      fsol3_q  <= fsol2_q;
      for (int s = 0; s < NSalt; s++) begin
        logic [31:0] n0, m;
        n0 = px_q ^ py_q ^ pf_q ^ (32'(s) * msw_pkg::HashKs);
        n_q[s] <= n0 ^ (n0 >> 13);
        m = n_q[s] * msw_pkg::HashKf;
        h_q[s] <= m[15:0];
      end
    end
  end

  // Compare hashes against thresholds.
  logic [msw_pkg::ThrW-1:0] t_noise, t_fall, t_dens, t_diag, t_horiz;
  assign t_noise = thr_i[msw_pkg::REG_SAND_NOISE*msw_pkg::ThrW +: msw_pkg::ThrW];
  assign t_fall  = thr_i[msw_pkg::REG_FALL_DOWN*msw_pkg::ThrW +: msw_pkg::ThrW];
  assign t_dens  = thr_i[msw_pkg::REG_DENSITY*msw_pkg::ThrW +: msw_pkg::ThrW];
  assign t_diag  = thr_i[msw_pkg::REG_DIAGONAL*msw_pkg::ThrW +: msw_pkg::ThrW];
  assign t_horiz = thr_i[msw_pkg::REG_HORIZONTAL*msw_pkg::ThrW +: msw_pkg::ThrW];

  assign out_valid_o        = s3_valid_q;
  assign out_o.tl           = cells3_q[7:6];
  assign out_o.tr           = cells3_q[5:4];
  assign out_o.bl           = cells3_q[3:2];
  assign out_o.br           = cells3_q[1:0];
  assign out_o.floor_solid  = fsol3_q;
  assign out_o.ch.noise     = {1'b0, h_q[0]} < t_noise;
  assign out_o.ch.fall      = {1'b0, h_q[1]} < t_fall;
  assign out_o.ch.dens      = {1'b0, h_q[2]} < t_dens;
  assign out_o.ch.diag      = {1'b0, h_q[3]} < t_diag;
  assign out_o.ch.horiz_top = {1'b0, h_q[4]} < t_horiz;
  assign out_o.ch.horiz_bot = {1'b0, h_q[5]} < t_horiz;

  // Stalled stage holds its item.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && !out_ready_i) |=> (s3_valid_q && $stable(cells3_q)))
    else $error("front stage lost a stalled item");

endmodule

@@ rtl/core/msw_queue.sv @@
// Two-entry queue between front and back.
module msw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msw_pkg::work_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msw_pkg::work_t out_data_o
);

  msw_pkg::work_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign wr          = in_valid_i && in_ready_o;
  assign rd          = out_valid_o && out_ready_i;

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Store item.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_data_i;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/msw_back.sv @@
// Back: apply sand and water moves, then register the result.
module msw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  msw_pkg::work_t in_i,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [1:0]     new_top_left_o,
  output logic [1:0]     new_top_right_o,
  output logic [1:0]     new_bottom_left_o,
  output logic [1:0]     new_bottom_right_o
);

  localparam logic [1:0] SAND  = msw_pkg::CELL_SAND;
  localparam logic [1:0] WATER = msw_pkg::CELL_WATER;

  logic       valid_q;
  logic [7:0] res_q;
  logic [1:0] tl, tr, bl, br, t;
  logic       moved, drop_l, drop_r;

  // Apply the rule.
  always_comb begin
    tl = in_i.tl; tr = in_i.tr; bl = in_i.bl; br = in_i.br;
    moved = 1'b0; drop_l = 1'b0; drop_r = 1'b0; t = 2'd0;
    if (!(tl == tr && bl == br && tl == bl)) begin
      if (((tl == SAND && tr < SAND) || (tr == SAND && tl < SAND)) &&
          bl < SAND && br < SAND && in_i.ch.noise) begin
        t = tl; tl = tr; tr = t; moved = 1'b1;
      end
      if (!moved && tl == SAND) begin
        if (bl < SAND) begin
          if (in_i.ch.fall) begin t = tl; tl = bl; bl = t; end
        end else if (tr < SAND && br < SAND) begin
          t = tl; tl = br; br = t;
        end
      end
      if (!moved && tr == SAND) begin
        if (br < SAND) begin
          if (in_i.ch.fall) begin t = tr; tr = br; br = t; end
        end else if (tl < SAND && bl < SAND) begin
          t = tr; tr = bl; bl = t;
        end
      end
      if (tl == WATER) begin
        if (bl < tl && in_i.ch.dens) begin
          t = tl; tl = bl; bl = t; drop_l = 1'b1;
        end else if (tr < tl && br < tl && in_i.ch.diag) begin
          t = tl; tl = br; br = t; drop_l = 1'b1;
        end
      end
      if (tr == WATER) begin
        if (br < tr && in_i.ch.dens) begin
          t = tr; tr = br; br = t; drop_r = 1'b1;
        end else if (tl < tr && bl < tr && in_i.ch.diag) begin
          t = tr; tr = bl; bl = t; drop_r = 1'b1;
        end
      end
      if (!drop_l && !drop_r &&
          ((tl == WATER && tr < WATER) || (tl < WATER && tr == WATER)) &&
          ((bl >= WATER && br >= WATER) || in_i.ch.horiz_top)) begin
        t = tl; tl = tr; tr = t;
      end
      if (((bl == WATER && br < WATER) || (bl < WATER && br == WATER)) &&
          (in_i.floor_solid || in_i.ch.horiz_bot)) begin
        t = bl; bl = br; br = t;
      end
    end
  end

  assign in_ready_o = !valid_q || pop_i;
  assign empty_o    = !valid_q;

  // Hold result until popped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (in_ready_o) valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) res_q <= {tl, tr, bl, br};
  end

  assign new_top_left_o     = res_q[7:6];
  assign new_top_right_o    = res_q[5:4];
  assign new_bottom_left_o  = res_q[3:2];
  assign new_bottom_right_o = res_q[1:0];

  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |=> (valid_q && $stable(res_q)))
    else $error("result changed while waiting");

endmodule

@@ rtl/core/margolus_sand_water_block_update.sv @@
// Top level: config registers, front, queue and back of the Margolus sand/water rule.
// One 2x2 block per cycle is accepted while full is low, and one result per cycle
// leaves while pop is held high. An accepted item passes four register stages,
// the three front hash stages (products, xor-shift, final multiply) and the queue,
// and then the result register; empty goes low when it reaches that register.
// While pop stays low the result register, the two-entry queue and the three
// front stages fill with six items in all, and then full rises.
module margolus_sand_water_block_update #(
  parameter int unsigned GRID_WIDTH  = 1024,
  parameter int unsigned GRID_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [9:0]  block_x_i,
  input  logic [9:0]  block_y_i,
  input  logic [31:0] frame_i,
  input  logic [1:0]  top_left_i,
  input  logic [1:0]  top_right_i,
  input  logic [1:0]  bottom_left_i,
  input  logic [1:0]  bottom_right_i,
  input  logic [1:0]  floor_left_i,
  input  logic [1:0]  floor_right_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  new_top_left_o,
  output logic [1:0]  new_top_right_o,
  output logic [1:0]  new_bottom_left_o,
  output logic [1:0]  new_bottom_right_o,
  input  logic        cfg_we_i,
  input  logic [msw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [msw_pkg::ThrW-1:0]    cfg_data_i
);

  logic [msw_pkg::ThrW-1:0] thr_q [msw_pkg::NumRegs];
  logic [msw_pkg::NumRegs*msw_pkg::ThrW-1:0] thr_flat;
  logic           front_ready, f_valid, q_ready, q_valid, b_ready;
  msw_pkg::work_t f_data, q_data;

  // Write threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[msw_pkg::REG_SAND_NOISE] <= 17'd26214;
      thr_q[msw_pkg::REG_FALL_DOWN]  <= 17'd58982;
      thr_q[msw_pkg::REG_DENSITY]    <= 17'd65535;
      thr_q[msw_pkg::REG_DIAGONAL]   <= 17'd32768;
      thr_q[msw_pkg::REG_HORIZONTAL] <= 17'd52428;
    end else if (cfg_we_i && cfg_idx_i <= msw_pkg::REG_HORIZONTAL) begin
      thr_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < msw_pkg::NumRegs; i++) begin
      thr_flat[i*msw_pkg::ThrW +: msw_pkg::ThrW] = thr_q[i];
    end
  end

  assign full = !front_ready;

  msw_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push), .in_ready_o(front_ready),
    .block_x_i, .block_y_i, .frame_i, .top_left_i, .top_right_i,
    .bottom_left_i, .bottom_right_i, .floor_left_i, .floor_right_i,
    .thr_i(thr_flat),
    .out_valid_o(f_valid), .out_ready_i(q_ready), .out_o(f_data)
  );

  msw_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(q_ready), .in_data_i(f_data),
    .out_valid_o(q_valid), .out_ready_i(b_ready), .out_data_o(q_data)
  );

  msw_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(b_ready), .in_i(q_data),
    .empty_o(empty), .pop_i(pop),
    .new_top_left_o, .new_top_right_o, .new_bottom_left_o, .new_bottom_right_o
  );

  a_uniform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && b_ready && q_data.tl == q_data.tr && q_data.bl == q_data.br &&
     q_data.tl == q_data.bl) |=> (new_top_left_o == $past(q_data.tl) &&
     new_bottom_right_o == $past(q_data.br)))
    else $error("uniform block was changed");

endmodule
